>>> design/gha_pkg.sv
// Shared types, constants and helpers of the generational handle allocator.
`default_nettype none

package gha_pkg;

    localparam int MAX_ENTITIES    = 1024;
    localparam int VERSION_BITS    = 8;
    localparam int NUM_COMPONENTS  = 32;
    localparam int RESERVE_DEFAULT = 16;

    localparam int IDX_W    = 10;
    localparam int VER_W    = VERSION_BITS;
    localparam int CID_W    = 5;
    localparam int FLAG_W   = 32;
    localparam int CNT_W    = 11;
    localparam int CMD_W    = 3;
    localparam int STS_W    = 3;
    localparam int CFG_W    = 10;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 2;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 88;

    localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_COPY   = 3'd5;

    localparam logic [STS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STS_W-1:0] ST_PRESENT    = 3'd1;
    localparam logic [STS_W-1:0] ST_ABSENT     = 3'd2;
    localparam logic [STS_W-1:0] ST_NONE_FREE  = 3'd3;
    localparam logic [STS_W-1:0] ST_NEVER      = 3'd4;

    localparam logic [APB_AW-1:0] REG_MIN_FREE = 2'd0;

    typedef struct packed {
        logic accept;
        logic reread;
        logic exec;
    } t_ctrl_cmd;

    typedef struct packed {
        logic             create_reuse;
        logic             out_blocked;
        logic [CNT_W-1:0] q_count;
        logic [CNT_W-1:0] fresh_count;
    } t_dp_sts;

    function automatic logic [IDX_W-1:0] ptr_next(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        r = (p == IDX_W'(MAX_ENTITIES - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/gha_ctrl.sv
// Sequencing state machine of the handle allocator.
`default_nettype none

module gha_ctrl
    import gha_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_s_tvalid,
    output logic           o_s_tready,
    input  wire t_dp_sts   i_sts,
    output t_ctrl_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOK   = 4'b0010,
        S_REREAD = 4'b0100,
        S_EXEC   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOOK;
                end
            end
            S_LOOK: begin
                if (i_sts.create_reuse) begin
                    o_cmd.reread = 1'b1;
                    n_state      = S_REREAD;
                end else if (!i_sts.out_blocked) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_REREAD: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!i_sts.out_blocked) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> design/gha_dp.sv
// Tables, free-index queue, command evaluation and result register.
`default_nettype none

module gha_dp
    import gha_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_ctrl_cmd              i_cmd,
    output t_dp_sts                     o_sts,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic [CMD_W-1:0]       i_s_tuser,
    input  wire logic [CFG_W-1:0]       i_min_reserve,
    input  wire logic                   i_m_tready,
    output logic                        o_m_tvalid,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    output logic [STS_W-1:0]            o_m_tuser
);

    logic [VER_W-1:0]  r_ver_mem  [MAX_ENTITIES];
    logic [FLAG_W-1:0] r_flag_mem [MAX_ENTITIES];
    logic [FLAG_W-1:0] r_old_mem  [MAX_ENTITIES];
    logic [IDX_W-1:0]  r_q_mem    [MAX_ENTITIES];

    logic [CMD_W-1:0]  r_cmd;
    logic [IDX_W-1:0]  r_idx;
    logic [VER_W-1:0]  r_ver;
    logic [CID_W-1:0]  r_cid;

    logic [VER_W-1:0]  r_rd_ver;
    logic [FLAG_W-1:0] r_rd_flags;
    logic [FLAG_W-1:0] r_rd_old;
    logic [IDX_W-1:0]  r_q_rd;

    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  r_tail;
    logic [CNT_W-1:0]  r_q_count;
    logic [CNT_W-1:0]  r_fresh;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [STS_W-1:0]       r_out_sts;

    logic [IDX_W-1:0]  in_idx;
    logic [IDX_W-1:0]  rd_addr;
    logic              rd_en;

    logic              known;
    logic              reuse;
    logic              fresh_ok;
    logic              q_not_full;
    logic              cid_ok;
    logic [FLAG_W-1:0] bit_mask;
    logic              has_bit;
    logic [VER_W-1:0]  ver_inc;

    logic              we_ver;
    logic              we_flags;
    logic              we_old;
    logic [IDX_W-1:0]  w_addr;
    logic [VER_W-1:0]  w_ver;
    logic [FLAG_W-1:0] w_flags;
    logic [FLAG_W-1:0] w_old;
    logic              q_push;
    logic              q_pop;
    logic              fresh_inc;

    logic [STS_W-1:0]  res_sts;
    logic [IDX_W-1:0]  res_idx;
    logic [VER_W-1:0]  res_ver;
    logic              res_valid;
    logic              res_has;
    logic [FLAG_W-1:0] res_flags;
    logic [FLAG_W-1:0] res_old;

    assign in_idx  = i_s_tdata[IDX_W-1:0];
    assign rd_addr = i_cmd.reread ? r_q_rd : in_idx;
    assign rd_en   = i_cmd.accept | i_cmd.reread;

    assign known      = ({1'b0, r_idx} < r_fresh);
    assign fresh_ok   = (r_fresh < CNT_W'(MAX_ENTITIES));
    assign q_not_full = (r_q_count < CNT_W'(MAX_ENTITIES));
    assign reuse      = (r_q_count > {1'b0, i_min_reserve})
                        || (!fresh_ok && (r_q_count != '0));
    assign cid_ok     = (int'(r_cid) < NUM_COMPONENTS);
    assign bit_mask   = cid_ok ? (FLAG_W'(1) << r_cid) : '0;
    assign has_bit    = |(r_rd_flags & bit_mask);
    assign ver_inc    = r_rd_ver + 1'b1;

    always_comb begin
        we_ver    = 1'b0;
        we_flags  = 1'b0;
        we_old    = 1'b0;
        w_addr    = r_idx;
        w_ver     = r_rd_ver;
        w_flags   = r_rd_flags;
        w_old     = r_rd_old;
        q_push    = 1'b0;
        q_pop     = 1'b0;
        fresh_inc = 1'b0;
        res_sts   = ST_OK;
        res_idx   = r_idx;
        res_ver   = r_rd_ver;
        res_valid = (r_rd_ver == r_ver);
        res_flags = r_rd_flags;
        res_old   = r_rd_old;
        if (r_cmd == CMD_CREATE) begin
            if (reuse) begin
                res_idx   = r_q_rd;
                res_valid = 1'b1;
                q_pop     = 1'b1;
            end else if (fresh_ok) begin
                res_idx   = r_fresh[IDX_W-1:0];
                res_ver   = '0;
                res_valid = 1'b1;
                res_flags = '0;
                res_old   = '0;
                w_addr    = r_fresh[IDX_W-1:0];
                w_ver     = '0;
                w_flags   = '0;
                w_old     = '0;
                we_ver    = 1'b1;
                we_flags  = 1'b1;
                we_old    = 1'b1;
                fresh_inc = 1'b1;
            end else begin
                res_sts   = ST_NONE_FREE;
                res_ver   = '0;
                res_valid = 1'b0;
                res_flags = '0;
                res_old   = '0;
            end
        end else if (!known) begin
            res_sts   = ST_NEVER;
            res_ver   = '0;
            res_valid = 1'b0;
            res_flags = '0;
            res_old   = '0;
        end else begin
            unique case (r_cmd)
                CMD_REMOVE: begin
                    w_ver    = ver_inc;
                    w_flags  = '0;
                    w_old    = '0;
                    we_ver   = 1'b1;
                    we_flags = 1'b1;
                    we_old   = 1'b1;
                    q_push   = q_not_full;
                end
                CMD_ADD: begin
                    if (!cid_ok) begin
                        res_sts = ST_ABSENT;
                    end else if (has_bit) begin
                        res_sts = ST_PRESENT;
                    end else begin
                        w_flags  = r_rd_flags | bit_mask;
                        we_flags = 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    if (!has_bit) begin
                        res_sts = ST_ABSENT;
                    end else begin
                        w_flags  = r_rd_flags & ~bit_mask;
                        we_flags = 1'b1;
                    end
                end
                CMD_COPY: begin
                    w_old  = r_rd_flags;
                    we_old = 1'b1;
                end
                default: begin
                end
            endcase
            res_ver   = w_ver;
            res_valid = (w_ver == r_ver);
            res_flags = w_flags;
            res_old   = w_old;
        end
        res_has = cid_ok & res_flags[r_cid];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && we_ver) begin
            r_ver_mem[w_addr] <= w_ver;
        end
        if (i_cmd.exec && we_flags) begin
            r_flag_mem[w_addr] <= w_flags;
        end
        if (i_cmd.exec && we_old) begin
            r_old_mem[w_addr] <= w_old;
        end
        if (i_cmd.exec && q_push) begin
            r_q_mem[r_tail] <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_ver   <= r_ver_mem[rd_addr];
            r_rd_flags <= r_flag_mem[rd_addr];
            r_rd_old   <= r_old_mem[rd_addr];
        end
        if (i_cmd.accept) begin
            r_q_rd <= r_q_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd <= i_s_tuser;
            r_idx <= in_idx;
            r_ver <= i_s_tdata[IDX_W +: VER_W];
            r_cid <= i_s_tdata[IDX_W + VER_W +: CID_W];
        end
        if (i_cmd.exec) begin
            r_out_sts  <= res_sts;
            r_out_data <= {4'b0000, res_old, res_flags, res_has, res_valid, res_ver, res_idx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_q_count   <= '0;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                if (q_pop) begin
                    r_head <= ptr_next(r_head);
                end
                if (q_push) begin
                    r_tail <= ptr_next(r_tail);
                end
                if (q_pop) begin
                    r_q_count <= r_q_count - 1'b1;
                end else if (q_push) begin
                    r_q_count <= r_q_count + 1'b1;
                end
                if (fresh_inc) begin
                    r_fresh <= r_fresh + 1'b1;
                end
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.create_reuse = (r_cmd == CMD_CREATE) && reuse;
    assign o_sts.out_blocked  = r_out_valid && !i_m_tready;
    assign o_sts.q_count      = r_q_count;
    assign o_sts.fresh_count  = r_fresh;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_sts;

endmodule

`default_nettype wire

>>> design/generational_handle_allocator_unit.sv
// Top level of the generational handle allocator: configuration register and block wiring.
`default_nettype none

// Hands out handles of index and version, keeps a component mask and a saved mask per
// index, and answers one result for every request. Requests are taken one at a time:
// a request passes from acceptance to a look step, which loads its result into the output
// register; a create that reuses a freed index goes on through a reread and an exec step,
// which loads its result, as the index popped from the free queue needs a second read of
// the tables through their single read port. A result waiting on the output side stalls
// the next request only at its last step. No clearing pass runs after reset; indices are
// handed out fresh in order first. min_free_reserve sits at byte address 0 and must be
// written by the user only while no request is open; the block does not enforce this.

module generational_handle_allocator_unit
    import gha_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // entity_index[9:0], entity_version[17:10], component_id[22:18], zero [23]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd[2:0]
    input  wire logic [CMD_W-1:0]       s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // handle_index[9:0], handle_version[17:10], is_valid[18], has_component[19],
    // flags[51:20], old_flags[83:52], zero [87:84]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // status[2:0]
    output logic [STS_W-1:0]            m_axis_tuser,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_AW-1:0]      paddr,
    input  wire logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]           prdata,
    output logic                        pready
);

    logic [CFG_W-1:0] r_min_reserve;
    t_ctrl_cmd        ctrl_cmd;
    t_dp_sts          dp_sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_reserve <= CFG_W'(RESERVE_DEFAULT);
        end else if (psel && penable && pwrite && pready) begin
            r_min_reserve <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr)
            REG_MIN_FREE: prdata = APB_DW'(r_min_reserve);
            default:      prdata = '0;
        endcase
    end

    gha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (dp_sts),
        .o_cmd      (ctrl_cmd)
    );

    gha_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctrl_cmd),
        .o_sts         (dp_sts),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_min_reserve (r_min_reserve),
        .i_m_tready    (m_axis_tready),
        .o_m_tvalid    (m_axis_tvalid),
        .o_m_tdata     (m_axis_tdata),
        .o_m_tuser     (m_axis_tuser)
    );

    a_exec_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.exec |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded while output slot occupied");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while previous one still open");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_sts.q_count <= CNT_W'(MAX_ENTITIES))
        && (dp_sts.fresh_count <= CNT_W'(MAX_ENTITIES)))
        else $error("queue or fresh count beyond table depth");

endmodule

`default_nettype wire
